/* hw/rtl/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, character constants and the base64 symbol mapping for the
// streaming base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  typedef enum logic {
    OpData   = 1'b0,
    OpFinish = 1'b1
  } op_e;

  localparam logic [7:0] PadChar      = 8'h3D;
  localparam logic [7:0] CrChar       = 8'h0D;
  localparam logic [7:0] LfChar       = 8'h0A;
  localparam logic [7:0] LineLimitRst = 8'd60;
  localparam logic [7:0] GroupChars   = 8'd4;

  // Character slots of one job: four symbols, then CR and LF when a break follows.
  localparam logic [2:0] SlotLastSym = 3'd3;
  localparam logic [2:0] SlotCr      = 3'd4;
  localparam logic [2:0] SlotLf      = 3'd5;

  // One unit of work for the back end: four characters, chars[0] goes first.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            crlf;
  } job_t;

  // Map a 6-bit value to the standard base64 alphabet.
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] s;
    case (v) inside
      [6'd0:6'd25]:  s = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: s = 8'h47 + {2'b00, v};
      [6'd52:6'd61]: s = {2'b00, v} - 8'd4;
      6'd62:         s = 8'h2B;
      default:       s = 8'h2F;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/b64e_front.sv */
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes and finish beats, holds a partial group, tracks the line
// count and turns each complete group or flushed tail into one job.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front import b64e_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic [7:0] cfg_line_limit_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [0:0] op_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output job_t            job_o
);

  logic [7:0] limit_q;
  logic [7:0] held0_q, held0_d;
  logic [7:0] held1_q, held1_d;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] line_q, line_d;

  logic       accept;
  logic       is_finish;
  logic       two_held;
  logic [7:0] b1_tail;
  logic [8:0] sum;
  logic       brk;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_finish  = (op_e'(op_i) == OpFinish);
  // A count of three never occurs; treat the high bit as "two held".
  assign two_held   = cnt_q[1];
  assign b1_tail    = two_held ? held1_q : 8'h00;
  assign sum        = {1'b0, line_q} + {1'b0, GroupChars};
  assign brk        = (sum >= {1'b0, limit_q});

  always_comb begin
    held0_d = held0_q;
    held1_d = held1_q;
    cnt_d   = cnt_q;
    line_d  = line_q;
    push_o  = 1'b0;
    job_o   = '0;
    if (accept) begin
      if (is_finish) begin
        // Flush a held tail with padding; the tail never breaks the line.
        if (cnt_q != 2'd0) begin
          push_o        = 1'b1;
          job_o.chars[0] = sym(held0_q[7:2]);
          job_o.chars[1] = sym({held0_q[1:0], b1_tail[7:4]});
          job_o.chars[2] = two_held ? sym({b1_tail[3:0], 2'b00}) : PadChar;
          job_o.chars[3] = PadChar;
          job_o.crlf     = 1'b0;
        end
        cnt_d  = 2'd0;
        line_d = 8'd0;
      end else if (!two_held) begin
        if (cnt_q[0]) begin
          held1_d = data_byte_i;
        end else begin
          held0_d = data_byte_i;
        end
        cnt_d = cnt_q + 2'd1;
      end else begin
        push_o         = 1'b1;
        job_o.chars[0] = sym(held0_q[7:2]);
        job_o.chars[1] = sym({held0_q[1:0], held1_q[7:4]});
        job_o.chars[2] = sym({held1_q[3:0], data_byte_i[7:6]});
        job_o.chars[3] = sym(data_byte_i[5:0]);
        job_o.crlf     = brk;
        cnt_d          = 2'd0;
        line_d         = brk ? 8'd0 : sum[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LineLimitRst;
      cnt_q   <= 2'd0;
      line_q  <= 8'd0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_line_limit_i;
      end
      cnt_q  <= cnt_d;
      line_q <= line_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held0_q <= held0_d;
    held1_q <= held1_d;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("held count reached three");
  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_finish |=> line_q == 8'd0 && cnt_q == 2'd0)
    else $error("finish did not clear counters");
  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> accept && (is_finish || two_held))
    else $error("job pushed without a completing beat");
`endif

endmodule

`default_nettype wire

/* hw/rtl/b64e_queue.sv */
// ----------------------------------------------------------------------------
// b64e_queue
// Small job queue between front and back end so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_queue import b64e_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  output logic      valid_o,
  input  wire logic pop_i,
  output job_t      job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/b64e_back.sv */
// ----------------------------------------------------------------------------
// b64e_back
// Serializes the head job into characters, one per cycle unless the output stalls,
// into an output register; appends CR LF when the job asks for a line break.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back import b64e_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire job_t job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output logic [7:0] out_char_o,
  output logic      last_o
);

  logic [2:0] slot_q;
  logic       valid_q;
  logic [7:0] char_q;
  logic       last_q;

  logic       load;
  logic       final_slot;
  logic [7:0] cur_char;

  assign load       = q_valid_i && (!valid_q || !out_stall_i);
  assign final_slot = job_i.crlf ? (slot_q == SlotLf) : (slot_q == SlotLastSym);
  assign pop_o      = load && final_slot;

  always_comb begin
    case (slot_q)
      SlotCr:  cur_char = CrChar;
      SlotLf:  cur_char = LfChar;
      default: cur_char = job_i.chars[slot_q[1:0]];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        slot_q  <= final_slot ? 3'd0 : slot_q + 3'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= cur_char;
      last_q <= final_slot;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SlotLf)
    else $error("slot index out of range");
  a_mid_job_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q != 3'd0 |-> q_valid_i)
    else $error("job left the queue before it was finished");
  a_break_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q > SlotLastSym |-> job_i.crlf)
    else $error("line break slot on a job without a break");
`endif

endmodule

`default_nettype wire

/* hw/rtl/base64_stream_encoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder with CR LF line wrapping and padded tail flush.
// ----------------------------------------------------------------------------
// Bytes enter one beat at a time on the input channel (op_i = data) and are
// grouped by three; each completed group becomes four characters of the
// standard base64 alphabet on the output channel, followed by CR LF when the
// running line count plus four reaches line_limit. A finish beat (op_i =
// finish) flushes one or two held bytes as four characters padded with '=',
// never breaks the line and clears the line count. last_o marks the final
// character caused by one input beat. Throughput is one output character
// per clock while the output is not stalled, set by the back-end serializer;
// the input takes a beat every cycle while the job queue has room. A
// completing beat's job is written into the queue, and the back end then
// loads its first character into the output register. Write line_limit
// only while the block is idle; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder import b64e_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration: line_limit write
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_line_limit_i,
  // input beats
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [0:0] op_i,
  input  wire logic [7:0] data_byte_i,
  // output beats
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_char_o,
  output logic            last_o
);

  logic q_full;
  logic q_valid;
  logic push;
  logic pop;
  job_t job_in;
  job_t job_head;

  // Configuration never waits.
  assign cfg_ready_o = 1'b1;

  // Front: hold partial groups, count line length, build jobs.
  b64e_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_line_limit_i (cfg_line_limit_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .data_byte_i      (data_byte_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .job_o            (job_in)
  );

  // Queue: decouple front acceptance from back-end output stalls.
  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .job_o   (job_head)
  );

  // Back: advance one character per cycle, unless the output stalls, into the output register.
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (job_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming base64 encoder. It feeds data and
// finish beats, predicts every output character from its own encoder model
// and compares the output stream character by character, with random idling
// on both channels and one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import b64e_pkg::*;

  // Slack after the last expected character before the block counts as idle.
  localparam int SettleCycles = 8;
  localparam int DrainLimit   = 20000;
  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       cfg_valid_i      = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_line_limit_i = 8'd0;
  logic       in_valid_i       = 1'b0;
  logic       in_stall_o;
  logic [0:0] op_i             = OpData;
  logic [7:0] data_byte_i      = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i      = 1'b0;
  logic [7:0] out_char_o;
  logic       last_o;

  // Encoder model state: held tail bytes, characters on the current line and
  // the programmed line limit.
  logic [7:0] tail_bytes [2];
  int         tail_len   = 0;
  logic [7:0] col_count  = 8'd0;
  logic [7:0] wrap_limit = LineLimitRst;
  char_beat_t pending_chars [$];

  int  fail_cnt    = 0;
  int  beats_sent  = 0;
  int  chars_seen  = 0;
  int  breaks_seen = 0;
  int  cfg_writes  = 0;
  bit  idling_on   = 1'b0;
  int  sink_hold   = 0;
  int  stall_burst = 0;

  base64_stream_encoder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_line_limit_i (cfg_line_limit_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .data_byte_i      (data_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_char_o       (out_char_o),
    .last_o           (last_o)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Encoder model
  // --------------------------------------------------------------------------
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    return Alphabet[8*(63 - int'(v)) +: 8];
  endfunction

  function automatic void emit_char(input logic [7:0] ch);
    char_beat_t cb;
    cb.ch   = ch;
    cb.last = 1'b0;
    pending_chars.push_back(cb);
  endfunction

  // Work out the characters that one accepted input beat causes.
  function automatic void encode_beat(input op_e op, input logic [7:0] b);
    int         n_before;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [8:0] sum;
    char_beat_t cb;
    n_before = pending_chars.size();
    if (op == OpData) begin
      if (tail_len < 2) begin
        // Hold the byte until the group is complete.
        tail_bytes[tail_len] = b;
        tail_len++;
      end else begin
        b0 = tail_bytes[0];
        b1 = tail_bytes[1];
        emit_char(b64_char(b0[7:2]));
        emit_char(b64_char({b0[1:0], b1[7:4]}));
        emit_char(b64_char({b1[3:0], b[7:6]}));
        emit_char(b64_char(b[5:0]));
        tail_len = 0;
        // Compare on the full sum so a count near 255 cannot wrap past the limit.
        sum = {1'b0, col_count} + 9'd4;
        if (sum >= {1'b0, wrap_limit}) begin
          emit_char(CrChar);
          emit_char(LfChar);
          col_count = 8'd0;
        end else begin
          col_count = sum[7:0];
        end
      end
    end else begin
      // Flush the tail with padding; never break the line here.
      if (tail_len != 0) begin
        b0 = tail_bytes[0];
        b1 = (tail_len == 2) ? tail_bytes[1] : 8'd0;
        emit_char(b64_char(b0[7:2]));
        emit_char(b64_char({b0[1:0], b1[7:4]}));
        emit_char((tail_len == 1) ? PadChar : b64_char({b1[3:0], 2'b00}));
        emit_char(PadChar);
      end
      tail_len  = 0;
      col_count = 8'd0;
    end
    if (pending_chars.size() > n_before) begin
      cb      = pending_chars.pop_back();
      cb.last = 1'b1;
      pending_chars.push_back(cb);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: stall generation and checking
  // --------------------------------------------------------------------------
  // A requested long hold wins over the short random bursts.
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      out_stall_i <= 1'b1;
      sink_hold--;
    end else if (stall_burst > 0) begin
      out_stall_i <= 1'b1;
      stall_burst--;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_burst = $urandom_range(1, 10) - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare every accepted output beat with the oldest expected character.
  always @(posedge clk_i) begin
    char_beat_t exp_cb;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chars_seen++;
      if (out_char_o == CrChar) breaks_seen++;
      if (pending_chars.size() == 0) begin
        $error("unexpected output beat: out_char %h last %b", out_char_o, last_o);
        fail_cnt++;
      end else begin
        exp_cb = pending_chars.pop_front();
        if (out_char_o !== exp_cb.ch) begin
          $error("out_char: expected %h, actual %h", exp_cb.ch, out_char_o);
          fail_cnt++;
        end
        if (last_o !== exp_cb.last) begin
          $error("last: expected %b, actual %b", exp_cb.last, last_o);
          fail_cnt++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one beat, optionally after an idle burst, and hold it until taken.
  // Valid is left high so a following beat can go out back to back.
  task automatic send_beat(input op_e op, input logic [7:0] b);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    encode_beat(op, b);
    beats_sent++;
  endtask

  // Drop valid and wait for every expected character, then let the block settle.
  task automatic drain_outputs();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_chars.size() != 0) begin
      $error("%0d expected characters never arrived", pending_chars.size());
      fail_cnt++;
      pending_chars.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Program line_limit; call only with the block idle.
  task automatic write_line_limit(input logic [7:0] lim);
    cfg_valid_i      <= 1'b1;
    cfg_line_limit_i <= lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    wrap_limit = lim;
    cfg_writes++;
  endtask

  // Favor the byte extremes now and then, otherwise any value.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // All-zero and all-one groups at the reset line limit.
  task automatic test_group_extremes();
    send_beat(OpData, 8'h00);
    send_beat(OpData, 8'h00);
    send_beat(OpData, 8'h00);
    send_beat(OpData, 8'hFF);
    send_beat(OpData, 8'hFF);
    send_beat(OpData, 8'hFF);
  endtask

  // Finish with nothing held, with one held byte and with two.
  task automatic test_tail_flush();
    send_beat(OpFinish, 8'hFF);
    send_beat(OpData, 8'hFF);
    send_beat(OpFinish, 8'h00);
    send_beat(OpData, 8'h00);
    send_beat(OpData, 8'hFF);
    send_beat(OpFinish, 8'hA5);
  endtask

  // A limit under one group breaks after every group but never after a tail.
  task automatic test_small_limit();
    drain_outputs();
    write_line_limit(8'd3);
    send_beat(OpData, 8'h4D);
    send_beat(OpData, 8'h61);
    send_beat(OpData, 8'h6E);
    send_beat(OpData, 8'h5A);
    send_beat(OpFinish, 8'h00);
  endtask

  // Build up a line count, then lower the limit so that the next group breaks.
  task automatic test_lowered_limit();
    int k;
    drain_outputs();
    write_line_limit(8'd255);
    for (k = 0; k < 6; k++) send_beat(OpData, pick_byte());
    drain_outputs();
    write_line_limit(8'd10);
    for (k = 0; k < 3; k++) send_beat(OpData, pick_byte());
  endtask

  // Mostly data bytes with occasional finish beats; idling switches on and off
  // in stretches. The phase always closes with a finish.
  task automatic test_random_stream(input logic [7:0] lim, input int n_beats,
                                    input int finish_pct);
    int k;
    drain_outputs();
    write_line_limit(lim);
    for (k = 0; k < n_beats; k++) begin
      if (k % 24 == 0) idling_on = ($urandom_range(0, 2) != 0);
      if (int'($urandom_range(0, 99)) < finish_pct) send_beat(OpFinish, 8'($urandom));
      else send_beat(OpData, pick_byte());
    end
    send_beat(OpFinish, 8'($urandom));
  endtask

  // Hold the output for a long stretch while bytes keep coming, so the job
  // queue fills and the input stalls.
  task automatic test_output_backpressure();
    int k;
    drain_outputs();
    idling_on = 1'b0;
    sink_hold = 80;
    for (k = 0; k < 24; k++) send_beat(OpData, pick_byte());
    send_beat(OpFinish, 8'h00);
  endtask

  // Back-to-back beats with no idling on either side.
  task automatic test_full_rate();
    int k;
    drain_outputs();
    idling_on = 1'b0;
    write_line_limit(8'($urandom_range(4, 40)));
    for (k = 0; k < 24; k++) send_beat(OpData, pick_byte());
    send_beat(OpData, pick_byte());
    send_beat(OpFinish, 8'h00);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    idling_on = 1'b1;
    test_group_extremes();
    test_tail_flush();
    test_small_limit();
    test_lowered_limit();

    // Break after every group, then a long unbroken run at the top limit so the
    // count climbs to 252 and must still break, then a random limit.
    test_random_stream(8'd4, 30, 15);
    test_random_stream(8'd255, 195, 0);
    test_random_stream(8'($urandom_range(4, 255)), 40, 10);

    test_output_backpressure();
    test_full_rate();
    drain_outputs();

    $display("Covered %0d input beats and %0d output characters, %0d of them line breaks,",
             beats_sent, chars_seen, breaks_seen);
    $display("across %0d line limit settings plus the reset value.", cfg_writes);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Give up well past the slowest correct run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_queue.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder.sv
verif/tb.sv
